### hdl/assert_macros.svh
// Assertion macros shared by the checker files of the sector cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SCC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sector cache assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SCC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sector cache assertion failed");

`endif

### hdl/scc_pkg.sv
// Shared widths and command codes of the sector cache engine.
package scc_pkg;

  localparam int CMD_W    = 2;
  localparam int SECTOR_W = 32;
  localparam int SLOT_W   = 6;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

endpackage

### hdl/scc_if.sv
// Request and response channel interfaces of the sector cache engine.
interface scc_req_if;
  logic                          valid;
  logic                          ready;
  logic [scc_pkg::CMD_W-1:0]     command;
  logic [scc_pkg::SECTOR_W-1:0]  sector;

  modport source (output valid, command, sector, input ready);
  modport sink   (input valid, command, sector, output ready);
endinterface

interface scc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [scc_pkg::SLOT_W-1:0]    slot;
  logic                          hit;
  logic                          fill;
  logic                          writeback;
  logic [scc_pkg::SECTOR_W-1:0]  writeback_sector;
  logic                          last;

  modport source (output valid, slot, hit, fill, writeback, writeback_sector, last,
                  input ready);
  modport sink   (input valid, slot, hit, fill, writeback, writeback_sector, last,
                  output ready);
endinterface

### hdl/scc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module scc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/sector_cache_clock_replacement_core.sv
// Tag and clock replacement engine of a fully associative sector cache. One request word
// is worked on at a time; the tag RAM has a single read port, so the tag search reads one
// slot per cycle. A miss scans all SLOTS tags, then walks the clock hand one slot per
// cycle, clearing set reference marks (at most SLOTS + 1 steps, the last of which reads
// the victim's tag), and registers the result word with any writeback report. A flush
// scans every slot and reports each valid dirty one as a writeback word; a word is held
// until the next is found, so the final one carries the last flag, and the response side
// can stall the scan. Valid, dirty and reference marks sit in flip-flops cleared by reset;
// the tag RAM is not cleared, as a tag is only read back for a valid slot. A new request
// is taken as soon as the last response word of the previous one, if any, sits in the
// output register.
module sector_cache_clock_replacement_core #(
  parameter int SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  scc_req_if.sink        req,
  scc_rsp_if.source      rsp
);
  import scc_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
  localparam logic [CW-1:0] CNT_END   = CW'(SLOTS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_HIT    = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_VICT   = 3'd4;
  localparam logic [2:0] S_FSCAN  = 3'd5;
  localparam logic [2:0] S_FREAD  = 3'd6;
  localparam logic [2:0] S_FLAST  = 3'd7;

  logic [2:0]          state;
  logic                cmd_write;
  logic [SECTOR_W-1:0] sector_r;
  logic [CW-1:0]       idx;
  logic                chk_vld;
  logic [SW-1:0]       chk_idx;
  logic [SW-1:0]       slot_r;
  logic [SW-1:0]       hand;
  logic [SLOTS-1:0]    valid_m;
  logic [SLOTS-1:0]    dirty_m;
  logic [SLOTS-1:0]    ref_m;
  logic                pend;
  logic [SW-1:0]       pend_slot;
  logic [SECTOR_W-1:0] pend_sector;

  logic                out_vld;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_hit;
  logic                out_fill;
  logic                out_wb;
  logic [SECTOR_W-1:0] out_wbs;
  logic                out_last;

  logic                ram_re;
  logic [SW-1:0]       ram_ra;
  logic                ram_we;
  logic [SECTOR_W-1:0] ram_rdata;
  logic                out_free;
  logic                match;
  logic                emit;
  logic [SW-1:0]       e_slot;
  logic                e_hit;
  logic                e_fill;
  logic                e_wb;
  logic [SECTOR_W-1:0] e_wbs;
  logic                e_last;

  scc_ram #(
    .WIDTH (SECTOR_W),
    .DEPTH (SLOTS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hand),
    .wdata (sector_r),
    .re    (ram_re),
    .raddr (ram_ra),
    .rdata (ram_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign out_free  = !out_vld || rsp.ready;
  assign match     = chk_vld && valid_m[chk_idx] && (ram_rdata == sector_r);

  assign rsp.valid            = out_vld;
  assign rsp.slot             = out_slot;
  assign rsp.hit              = out_hit;
  assign rsp.fill             = out_fill;
  assign rsp.writeback        = out_wb;
  assign rsp.writeback_sector = out_wbs;
  assign rsp.last             = out_last;

  always_comb begin
    ram_re = 1'b0;
    ram_ra = idx[SW-1:0];
    ram_we = 1'b0;
    emit   = 1'b0;
    e_slot = slot_r;
    e_hit  = 1'b0;
    e_fill = 1'b0;
    e_wb   = 1'b0;
    e_wbs  = '0;
    e_last = 1'b1;
    unique case (state)
      S_SEARCH: begin
        ram_re = !match && (idx != CNT_END);
      end
      S_HIT: begin
        emit  = out_free;
        e_hit = 1'b1;
      end
      S_WALK: begin
        ram_re = !ref_m[hand];
        ram_ra = hand;
      end
      S_VICT: begin
        emit   = out_free;
        ram_we = out_free;
        e_slot = hand;
        e_fill = 1'b1;
        e_wb   = valid_m[hand] && dirty_m[hand];
        e_wbs  = e_wb ? ram_rdata : '0;
      end
      S_FSCAN: begin
        ram_re = (idx != CNT_END) && valid_m[idx[SW-1:0]] && dirty_m[idx[SW-1:0]];
      end
      S_FREAD: begin
        // A newer dirty slot was found, so the held one is not the final word.
        emit   = pend && out_free;
        e_slot = pend_slot;
        e_wb   = 1'b1;
        e_wbs  = pend_sector;
        e_last = 1'b0;
      end
      S_FLAST: begin
        emit   = out_free;
        e_slot = pend_slot;
        e_wb   = 1'b1;
        e_wbs  = pend_sector;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      valid_m <= '0;
      dirty_m <= '0;
      ref_m   <= '0;
      hand    <= '0;
      out_vld <= 1'b0;
      chk_vld <= 1'b0;
      pend    <= 1'b0;
    end else begin
      if (emit) begin
        out_vld  <= 1'b1;
        out_slot <= SLOT_W'(e_slot);
        out_hit  <= e_hit;
        out_fill <= e_fill;
        out_wb   <= e_wb;
        out_wbs  <= e_wbs;
        out_last <= e_last;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_write <= (req.command == CMD_WRITE);
            sector_r  <= req.sector;
            idx       <= '0;
            chk_vld   <= 1'b0;
            pend      <= 1'b0;
            case (req.command) inside
              CMD_READ, CMD_WRITE: state <= S_SEARCH;
              CMD_FLUSH:           state <= S_FSCAN;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_SEARCH: begin
          chk_vld <= ram_re;
          chk_idx <= idx[SW-1:0];
          if (ram_re) begin
            idx <= idx + 1'b1;
          end
          if (match) begin
            slot_r <= chk_idx;
            state  <= S_HIT;
          end else if (chk_vld && chk_idx == LAST_SLOT) begin
            state <= S_WALK;
          end
        end
        S_HIT: begin
          if (out_free) begin
            ref_m[slot_r] <= 1'b1;
            if (cmd_write) begin
              dirty_m[slot_r] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        S_WALK: begin
          // Second chance: a set reference mark is cleared and the hand moves on.
          if (ref_m[hand]) begin
            ref_m[hand] <= 1'b0;
            hand        <= (hand == LAST_SLOT) ? '0 : hand + 1'b1;
          end else begin
            state <= S_VICT;
          end
        end
        S_VICT: begin
          if (out_free) begin
            valid_m[hand] <= 1'b1;
            dirty_m[hand] <= cmd_write;
            ref_m[hand]   <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_FSCAN: begin
          if (idx == CNT_END) begin
            state <= pend ? S_FLAST : S_IDLE;
          end else if (ram_re) begin
            state <= S_FREAD;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_FREAD: begin
          if (!pend || out_free) begin
            pend        <= 1'b1;
            pend_slot   <= idx[SW-1:0];
            pend_sector <= ram_rdata;
            idx         <= idx + 1'b1;
            state       <= S_FSCAN;
          end
        end
        S_FLAST: begin
          if (out_free) begin
            pend  <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/scc_checker.sv
// Port-level checker of the sector cache engine and its bind to the top level.
`include "assert_macros.svh"

module scc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic [scc_pkg::CMD_W-1:0]     req_command,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          rsp_hit,
  input logic                          rsp_fill,
  input logic                          rsp_writeback,
  input logic [scc_pkg::SECTOR_W-1:0]  rsp_writeback_sector,
  input logic                          rsp_last
);
  import scc_pkg::*;

  // A stalled response word stays offered.
  `SCC_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)

  // An access answers with one word, which is both hit-or-fill and final.
  `SCC_ASSERT_IMP(a_access_last, clk, rst, rsp_valid && (rsp_hit || rsp_fill), rsp_last)

  `SCC_ASSERT_IMP(a_hit_clean, clk, rst, rsp_valid && rsp_hit, !rsp_fill && !rsp_writeback)

  `SCC_ASSERT_IMP(a_wb_sector_zero, clk, rst, rsp_valid && !rsp_writeback, rsp_writeback_sector == '0)

  // Any real command keeps the engine busy for at least the next cycle.
  `SCC_ASSERT_NXT(a_busy_after_accept, clk, rst, req_valid && req_ready && req_command != CMD_NONE, !req_ready)

endmodule

bind sector_cache_clock_replacement_core scc_checker u_scc_checker (
  .clk                  (clk),
  .rst                  (rst),
  .req_valid            (req.valid),
  .req_ready            (req.ready),
  .req_command          (req.command),
  .rsp_valid            (rsp.valid),
  .rsp_ready            (rsp.ready),
  .rsp_hit              (rsp.hit),
  .rsp_fill             (rsp.fill),
  .rsp_writeback        (rsp.writeback),
  .rsp_writeback_sector (rsp.writeback_sector),
  .rsp_last             (rsp.last)
);
